FILE: hdl/tac_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tac_pkg
// Shared types and constants for the tiny accumulator CPU.
// ----------------------------------------------------------------------------
package tac_pkg;

  localparam int unsigned MemDepth = 16;
  localparam int unsigned AddrW    = 4;
  localparam int unsigned DataW    = 8;

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [DataW-1:0] data_t;

  // word kind on the input channel
  typedef enum logic {
    KIND_STEP  = 1'b0,
    KIND_WRITE = 1'b1
  } kind_e;

  typedef enum logic [3:0] {
    OP_NOP = 4'h0,
    OP_LDA = 4'h1,
    OP_ADD = 4'h2,
    OP_SUB = 4'h3,
    OP_STA = 4'h4,
    OP_LDI = 4'h5,
    OP_JMP = 4'h6,
    OP_JC  = 4'h7,
    OP_JZ  = 4'h8,
    OP_OUT = 4'hE,
    OP_HLT = 4'hF
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_HALT    = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

  typedef struct packed {
    addr_t pc;
    data_t a;
    data_t b;
    data_t out;
    logic  carry;
    logic  zero;
  } cpu_state_t;

  typedef struct packed {
    logic  we;
    addr_t addr;
    data_t data;
  } mem_wr_t;

  typedef struct packed {
    status_e status;
    logic    shown;
    data_t   out_value;
    addr_t   pc;
    data_t   acc;
  } result_t;

endpackage
`default_nettype wire

FILE: hdl/tac_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tac_mem
// 16 x 8 program/data register file, one write port, two read ports.
// ----------------------------------------------------------------------------
module tac_mem (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire tac_pkg::mem_wr_t wr_i,
  input  wire tac_pkg::addr_t  raddr0_i,
  input  wire tac_pkg::addr_t  raddr1_i,
  output tac_pkg::data_t       rdata0_o,
  output tac_pkg::data_t       rdata1_o
);

  tac_pkg::data_t mem_q [tac_pkg::MemDepth];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < tac_pkg::MemDepth; i++) begin
        mem_q[i] <= '0;
      end
    end else if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  assign rdata0_o = mem_q[raddr0_i];
  assign rdata1_o = mem_q[raddr1_i];

endmodule
`default_nettype wire

FILE: hdl/tac_exec.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tac_exec
// Decode and execute of one word: next CPU state, memory write and result.
// ----------------------------------------------------------------------------
module tac_exec (
  input  wire tac_pkg::kind_e     kind_i,
  input  wire tac_pkg::addr_t     addr_i,
  input  wire tac_pkg::data_t     data_i,
  input  wire tac_pkg::cpu_state_t state_i,
  input  wire tac_pkg::data_t     ir_i,
  input  wire tac_pkg::data_t     opnd_i,
  output tac_pkg::cpu_state_t     state_o,
  output tac_pkg::mem_wr_t        wr_o,
  output tac_pkg::result_t        res_o
);

  tac_pkg::addr_t          arg;
  tac_pkg::addr_t          pc_inc;
  logic [tac_pkg::DataW:0] sum;
  tac_pkg::data_t          diff;
  tac_pkg::status_e        status;
  logic                    shown;

  assign arg    = ir_i[tac_pkg::AddrW-1:0];
  assign pc_inc = state_i.pc + tac_pkg::addr_t'(1);
  assign sum    = {1'b0, state_i.a} + {1'b0, opnd_i};
  assign diff   = state_i.a - opnd_i;

  always_comb begin
    state_o = state_i;
    wr_o    = '{we: 1'b0, addr: arg, data: state_i.a};
    status  = tac_pkg::ST_OK;
    shown   = 1'b0;
    if (kind_i == tac_pkg::KIND_WRITE) begin
      wr_o = '{we: 1'b1, addr: addr_i, data: data_i};
    end else begin
      unique case (tac_pkg::op_e'(ir_i[tac_pkg::DataW-1:tac_pkg::AddrW]))
        tac_pkg::OP_NOP: state_o.pc = pc_inc;
        tac_pkg::OP_LDA: begin
          state_o.a  = opnd_i;
          state_o.pc = pc_inc;
        end
        tac_pkg::OP_ADD: begin
          state_o.b     = opnd_i;
          state_o.a     = sum[tac_pkg::DataW-1:0];
          state_o.carry = sum[tac_pkg::DataW];
          state_o.zero  = (sum[tac_pkg::DataW-1:0] == '0);
          state_o.pc    = pc_inc;
        end
        tac_pkg::OP_SUB: begin
          state_o.b     = opnd_i;
          state_o.a     = diff;
          state_o.carry = (state_i.a >= opnd_i);
          state_o.zero  = (diff == '0);
          state_o.pc    = pc_inc;
        end
        tac_pkg::OP_STA: begin
          wr_o.we    = 1'b1;
          state_o.pc = pc_inc;
        end
        tac_pkg::OP_LDI: begin
          state_o.a  = {{(tac_pkg::DataW-tac_pkg::AddrW){1'b0}}, arg};
          state_o.pc = pc_inc;
        end
        tac_pkg::OP_JMP: state_o.pc = arg;
        tac_pkg::OP_JC:  state_o.pc = state_i.carry ? arg : pc_inc;
        tac_pkg::OP_JZ:  state_o.pc = state_i.zero ? arg : pc_inc;
        tac_pkg::OP_OUT: begin
          state_o.out = state_i.a;
          shown       = 1'b1;
          state_o.pc  = pc_inc;
        end
        tac_pkg::OP_HLT: status = tac_pkg::ST_HALT;
        default:         status = tac_pkg::ST_INVALID;
      endcase
    end
  end

  assign res_o = '{status:    status,
                   shown:     shown,
                   out_value: state_o.out,
                   pc:        state_o.pc,
                   acc:       state_o.a};

endmodule
`default_nettype wire

FILE: hdl/tiny_accumulator_cpu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tiny_accumulator_cpu
// Accumulator CPU with a 16-byte program/data memory, one word per step.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_ready_o): each word either writes one memory
// byte (opcode_i = 1) or executes one instruction at the PC (opcode_i = 0).
// Result channel (res_valid_o / res_ready_i): exactly one result word per
// input word, in order: status, OUT flag, output register, PC and A.
// From input acceptance to result valid: input register, then
// combinational fetch/decode/execute into the result register. Throughput:
// one word per cycle unless stalled; the execute step reads the register
// file twice (instruction, then operand) and updates state in the same cycle.
// While the receiver stalls, the result register holds its word and the
// input register holds at most one more word; in_ready_o drops once both
// are full and recovers in the cycle res_ready_i returns.
// Reset clears memory, PC, A, B, output register, flags and both valid bits.
// ----------------------------------------------------------------------------
module tiny_accumulator_cpu (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       opcode_i,
  input  wire logic [3:0] mem_address_i,
  input  wire logic [7:0] mem_data_i,
  output logic            res_valid_o,
  input  wire logic       res_ready_i,
  output logic [1:0]      status_o,
  output logic            out_valid_o,
  output logic [7:0]      out_value_o,
  output logic [3:0]      pc_value_o,
  output logic [7:0]      acc_value_o
);

  logic                in_vld_q;
  tac_pkg::kind_e      kind_q;
  tac_pkg::addr_t      addr_q;
  tac_pkg::data_t      data_q;

  tac_pkg::cpu_state_t state_q;
  tac_pkg::cpu_state_t state_d;
  tac_pkg::mem_wr_t    wr;
  tac_pkg::mem_wr_t    wr_gated;
  tac_pkg::data_t      ir;
  tac_pkg::data_t      opnd;
  tac_pkg::result_t    res_d;
  tac_pkg::result_t    res_q;
  logic                res_vld_q;

  logic                res_free;
  logic                exec_fire;

  assign res_free   = !res_vld_q || res_ready_i;
  assign exec_fire  = in_vld_q && res_free;
  assign in_ready_o = !in_vld_q || exec_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      kind_q <= tac_pkg::kind_e'(opcode_i);
      addr_q <= mem_address_i;
      data_q <= mem_data_i;
    end
  end

  tac_mem u_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (wr_gated),
    .raddr0_i (state_q.pc),
    .raddr1_i (ir[tac_pkg::AddrW-1:0]),
    .rdata0_o (ir),
    .rdata1_o (opnd)
  );

  tac_exec u_exec (
    .kind_i  (kind_q),
    .addr_i  (addr_q),
    .data_i  (data_q),
    .state_i (state_q),
    .ir_i    (ir),
    .opnd_i  (opnd),
    .state_o (state_d),
    .wr_o    (wr),
    .res_o   (res_d)
  );

  always_comb begin
    wr_gated    = wr;
    wr_gated.we = wr.we && exec_fire;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (exec_fire) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (res_free) begin
      res_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_vld_q;
  assign status_o    = res_q.status;
  assign out_valid_o = res_q.shown;
  assign out_value_o = res_q.out_value;
  assign pc_value_o  = res_q.pc;
  assign acc_value_o = res_q.acc;

endmodule
`default_nettype wire
